FILE: design/bir_pkg.sv
// Shared types and constants of the bilinear image resize unit.
package bir_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_SCALE_X    = 2'd2,
        CFG_SCALE_Y    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_op         op;
        logic [7:0]  cx;
        logic [7:0]  cy;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pixel;
    } t_item;

    typedef struct packed {
        logic [15:0] wm1;
        logic [15:0] hm1;
    } t_geom;

endpackage

FILE: design/bir_front.sv
// Front end: accepts requests, computes source positions and drops loads outside the store.
module bir_front #(
    parameter int MAX_WIDTH  = bir_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bir_pkg::MAX_HEIGHT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_op,
    input  logic [7:0]     i_coord_x,
    input  logic [7:0]     i_coord_y,
    input  logic [7:0]     i_in_red,
    input  logic [7:0]     i_in_green,
    input  logic [7:0]     i_in_blue,
    input  logic [7:0]     i_in_alpha,
    input  logic [23:0]    i_scale_x,
    input  logic [23:0]    i_scale_y,
    output logic           o_push,
    output bir_pkg::t_item o_item,
    input  logic           i_full
);
    import bir_pkg::*;

    logic  r_fv;
    t_item r_item;
    logic  keep;
    logic  done;

    assign keep    = (r_item.op == OP_SAMPLE) ||
                     ((32'(r_item.cx) < 32'(MAX_WIDTH)) && (32'(r_item.cy) < 32'(MAX_HEIGHT)));
    assign o_push  = r_fv && keep && !i_full;
    assign done    = r_fv && (!keep || !i_full);
    assign o_ready = !r_fv || done;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (o_ready) begin
            r_fv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.op    <= t_op'(i_op);
            r_item.cx    <= i_coord_x;
            r_item.cy    <= i_coord_y;
            r_item.pos_x <= {24'd0, i_coord_x} * {8'd0, i_scale_x};
            r_item.pos_y <= {24'd0, i_coord_y} * {8'd0, i_scale_y};
            r_item.pixel <= {i_in_alpha, i_in_blue, i_in_green, i_in_red};
        end
    end

endmodule

FILE: design/bir_queue.sv
// Short request queue between the front end and the interpolation back end.
module bir_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bir_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output bir_pkg::t_item o_item,
    output logic           o_empty
);
    import bir_pkg::*;

    t_item             r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_buf[r_wp] <= i_item;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("queue read while empty");
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("queue count did not fall on a read");

endmodule

FILE: design/bir_back.sv
// Back end: banked pixel store, neighbour fetch and bilinear blend pipeline.
module bir_back #(
    parameter int MAX_WIDTH  = bir_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bir_pkg::MAX_HEIGHT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bir_pkg::t_geom i_geom,
    input  bir_pkg::t_item i_item,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_out_x,
    output logic [7:0]     o_out_y,
    output logic [7:0]     o_out_red,
    output logic [7:0]     o_out_green,
    output logic [7:0]     o_out_blue,
    output logic [7:0]     o_out_alpha
);
    import bir_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int CW = ($clog2((MAX_WIDTH + 1) / 2) > 0) ? $clog2((MAX_WIDTH + 1) / 2) : 1;
    localparam int RW = ($clog2((MAX_HEIGHT + 1) / 2) > 0) ? $clog2((MAX_HEIGHT + 1) / 2) : 1;
    localparam int BANK_DEPTH = 2 ** (CW + RW);

    logic          adv;
    logic [15:0]   xi, yi;
    logic [XW-1:0] x1;
    logic [YW-1:0] y1;
    logic          clx, cly;
    logic [XW:0]   xt;
    logic [YW:0]   yt;
    logic [CW-1:0] col_e, col_o;
    logic [RW-1:0] row_e, row_o;
    logic          wr_en;
    logic [1:0]    wr_bank;
    logic [CW+RW-1:0] wr_addr;

    logic [31:0]   r_rd [4];
    logic          r_v2, r_clx, r_cly, r_x1p, r_y1p;
    logic [7:0]    r_fx2, r_fy2, r_cx2, r_cy2;
    logic          xo, yo;
    logic [31:0]   p11, p21, p12, p22;
    logic [8:0]    wx, wy;

    logic          r_v3;
    logic [7:0]    r_fy3, r_cx3, r_cy3;
    logic [15:0]   r_top [4];
    logic [15:0]   r_bot [4];

    logic          r_v4;
    logic [7:0]    r_cx4, r_cy4;
    logic [23:0]   r_sum [4];
    logic [23:0]   rnd [4];

    logic          r_v5;
    logic [7:0]    r_ox, r_oy;
    logic [7:0]    r_ch [4];

    assign adv   = !r_v5 || i_ready;
    assign o_pop = !i_empty && adv;

    assign xi  = i_item.pos_x[31:16];
    assign yi  = i_item.pos_y[31:16];
    assign x1  = (xi > i_geom.wm1) ? XW'(i_geom.wm1) : XW'(xi);
    assign y1  = (yi > i_geom.hm1) ? YW'(i_geom.hm1) : YW'(yi);
    assign clx = (16'(x1) == i_geom.wm1);
    assign cly = (16'(y1) == i_geom.hm1);
    assign xt  = {1'b0, x1} + (XW+1)'(x1[0]);
    assign yt  = {1'b0, y1} + (YW+1)'(y1[0]);
    assign col_e = CW'(xt >> 1);
    assign col_o = CW'(x1 >> 1);
    assign row_e = RW'(yt >> 1);
    assign row_o = RW'(y1 >> 1);

    assign wr_en   = o_pop && (i_item.op == OP_LOAD);
    assign wr_bank = {i_item.cy[0], i_item.cx[0]};
    assign wr_addr = {RW'(i_item.cy >> 1), CW'(i_item.cx >> 1)};

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [31:0]      r_mem [BANK_DEPTH];
        logic [CW+RW-1:0] rd_addr;
        assign rd_addr = {(b / 2 == 1) ? row_o : row_e, (b % 2 == 1) ? col_o : col_e};
        always_ff @(posedge i_clk) begin
            if (wr_en && (wr_bank == 2'(b))) r_mem[wr_addr] <= i_item.pixel;
            if (adv) r_rd[b] <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (adv) begin
            r_v2 <= o_pop && (i_item.op == OP_SAMPLE);
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    assign xo  = r_clx ? r_x1p : ~r_x1p;
    assign yo  = r_cly ? r_y1p : ~r_y1p;
    assign p11 = r_rd[{r_y1p, r_x1p}];
    assign p21 = r_rd[{r_y1p, xo}];
    assign p12 = r_rd[{yo, r_x1p}];
    assign p22 = r_rd[{yo, xo}];
    assign wx  = 9'd256 - {1'b0, r_fx2};
    assign wy  = 9'd256 - {1'b0, r_fy3};

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_clx <= clx;
            r_cly <= cly;
            r_x1p <= x1[0];
            r_y1p <= y1[0];
            r_fx2 <= i_item.pos_x[15:8];
            r_fy2 <= i_item.pos_y[15:8];
            r_cx2 <= i_item.cx;
            r_cy2 <= i_item.cy;
            r_fy3 <= r_fy2;
            r_cx3 <= r_cx2;
            r_cy3 <= r_cy2;
            r_cx4 <= r_cx3;
            r_cy4 <= r_cy3;
            r_ox  <= r_cx4;
            r_oy  <= r_cy4;
            for (int c = 0; c < 4; c++) begin
                r_top[c] <= 16'(p11[8*c +: 8]) * 16'(wx) + 16'(p21[8*c +: 8]) * 16'(r_fx2);
                r_bot[c] <= 16'(p12[8*c +: 8]) * 16'(wx) + 16'(p22[8*c +: 8]) * 16'(r_fx2);
                r_sum[c] <= 24'(r_top[c]) * 24'(wy) + 24'(r_bot[c]) * 24'(r_fy3);
                r_ch[c]  <= rnd[c][23:16];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            rnd[c] = r_sum[c] + 24'd32768;
        end
    end

    assign o_valid     = r_v5;
    assign o_out_x     = r_ox;
    assign o_out_y     = r_oy;
    assign o_out_red   = r_ch[0];
    assign o_out_green = r_ch[1];
    assign o_out_blue  = r_ch[2];
    assign o_out_alpha = r_ch[3];

    a_hold_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !adv) |=> r_v2) else $error("fetch stage lost a request in a stall");
    a_flow_s4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && adv) |=> r_v5) else $error("blend result did not reach the output");
    a_pop_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && !i_ready) |-> !o_pop) else $error("queue read while output stalled");

endmodule

FILE: design/bilinear_image_resize_unit.sv
// Top level of the bilinear image resize unit: configuration registers and block wiring.
//
// Requests enter on i_valid/o_ready with i_op, i_coord_x/y and the four pixel channels.
// A load request (op 0) writes one RGBA8 pixel into the banked pixel store and gives no
// result; a load outside the store is dropped. A sample request (op 1) maps the target
// coordinate through the Q8.16 scale registers, fetches the four neighbours together
// from four banks split by column and row parity, and gives one blended pixel on
// o_valid/i_ready together with the echoed coordinate.
// Throughput is one request per cycle while the queue has room and the output is not
// stalled. A sample result passes through the front register, queue, store read,
// horizontal blend, vertical blend and output register.
// A stalled receiver holds the whole back end; the front end then keeps accepting until
// the four-entry queue is full, after which o_ready falls.
// Reset is synchronous and active low; it empties the pipeline and queue and restores the
// configuration defaults. The pixel store is not cleared and holds no valid data until
// written. Configuration writes via i_cfg_we take effect at once and are meant for idle.
module bilinear_image_resize_unit #(
    parameter int MAX_WIDTH  = bir_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bir_pkg::MAX_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_coord_x,
    input  logic [7:0]  i_coord_y,
    input  logic [7:0]  i_in_red,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_blue,
    input  logic [7:0]  i_in_alpha,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_x,
    output logic [7:0]  o_out_y,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_alpha
);
    import bir_pkg::*;

    logic [8:0]  r_src_w, r_src_h;
    logic [23:0] r_scale_x, r_scale_y;
    t_geom       geom;
    logic        push, full, pop, empty;
    t_item       f_item, q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w   <= 9'd256;
            r_src_h   <= 9'd256;
            r_scale_x <= 24'd65536;
            r_scale_y <= 24'd65536;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SRC_WIDTH:  r_src_w   <= i_cfg_data[8:0];
                CFG_SRC_HEIGHT: r_src_h   <= i_cfg_data[8:0];
                CFG_SCALE_X:    r_scale_x <= i_cfg_data;
                CFG_SCALE_Y:    r_scale_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_src_w == 9'd0) begin
            geom.wm1 = 16'd0;
        end else if (32'(r_src_w) > 32'(MAX_WIDTH)) begin
            geom.wm1 = 16'(MAX_WIDTH - 1);
        end else begin
            geom.wm1 = 16'(r_src_w) - 16'd1;
        end
        if (r_src_h == 9'd0) begin
            geom.hm1 = 16'd0;
        end else if (32'(r_src_h) > 32'(MAX_HEIGHT)) begin
            geom.hm1 = 16'(MAX_HEIGHT - 1);
        end else begin
            geom.hm1 = 16'(r_src_h) - 16'd1;
        end
    end

    bir_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_op, .i_coord_x, .i_coord_y,
        .i_in_red, .i_in_green, .i_in_blue, .i_in_alpha,
        .i_scale_x(r_scale_x), .i_scale_y(r_scale_y),
        .o_push(push), .o_item(f_item), .i_full(full)
    );

    bir_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_item(f_item), .o_full(full),
        .i_pop(pop), .o_item(q_item), .o_empty(empty)
    );

    bir_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .i_clk, .i_rst_n, .i_geom(geom), .i_item(q_item), .i_empty(empty), .o_pop(pop),
        .o_valid, .i_ready, .o_out_x, .o_out_y, .o_out_red, .o_out_green,
        .o_out_blue, .o_out_alpha
    );

endmodule

FILE: tb/bir_checker.sv
// Checker of the bilinear image resize unit: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module bir_checker
    import bir_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic        i_op,
    input  logic [7:0]  i_coord_x,
    input  logic [7:0]  i_coord_y,
    input  logic [7:0]  i_in_red,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_blue,
    input  logic [7:0]  i_in_alpha,
    input  logic        i_valid_out,
    input  logic        i_ready,
    input  logic [7:0]  i_out_x,
    input  logic [7:0]  i_out_y,
    input  logic [7:0]  i_out_red,
    input  logic [7:0]  i_out_green,
    input  logic [7:0]  i_out_blue,
    input  logic [7:0]  i_out_alpha,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pixel_out;

    logic [31:0] image_mem [0:65535];
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [23:0] step_x;
    logic [23:0] step_y;
    t_pixel_out  pixels_due [$];

    function automatic logic [8:0] clamp_size(logic [8:0] v);
        if (v == 9'd0) begin
            return 9'd1;
        end
        if (v > 9'd256) begin
            return 9'd256;
        end
        return v;
    endfunction

    function automatic t_pixel_out blend_pixel(logic [7:0] cx, logic [7:0] cy);
        t_pixel_out  r;
        logic [8:0]  w;
        logic [8:0]  h;
        logic [31:0] px;
        logic [31:0] py;
        logic [15:0] x1;
        logic [15:0] y1;
        logic [15:0] x2;
        logic [15:0] y2;
        logic [8:0]  fx;
        logic [8:0]  fy;
        logic [31:0] p11;
        logic [31:0] p21;
        logic [31:0] p12;
        logic [31:0] p22;
        logic [31:0] top;
        logic [31:0] bot;
        logic [31:0] v;
        logic [7:0]  ch [4];
        w = clamp_size(width_reg);
        h = clamp_size(height_reg);
        px = 32'(cx) * 32'(step_x);
        py = 32'(cy) * 32'(step_y);
        x1 = px[31:16];
        y1 = py[31:16];
        if (x1 > w - 1) x1 = w - 1;
        if (y1 > h - 1) y1 = h - 1;
        x2 = (x1 + 1 < w) ? x1 + 1 : w - 1;
        y2 = (y1 + 1 < h) ? y1 + 1 : h - 1;
        fx = {1'b0, px[15:8]};
        fy = {1'b0, py[15:8]};
        p11 = image_mem[{y1[7:0], x1[7:0]}];
        p21 = image_mem[{y1[7:0], x2[7:0]}];
        p12 = image_mem[{y2[7:0], x1[7:0]}];
        p22 = image_mem[{y2[7:0], x2[7:0]}];
        for (int c = 0; c < 4; c++) begin
            top = 32'(p11[8*c +: 8]) * (256 - fx) + 32'(p21[8*c +: 8]) * fx;
            bot = 32'(p12[8*c +: 8]) * (256 - fx) + 32'(p22[8*c +: 8]) * fx;
            v = top * (256 - fy) + bot * fy;
            ch[c] = 8'((v + 32'd32768) >> 16);
        end
        r.x = cx;
        r.y = cy;
        r.red = ch[0];
        r.green = ch[1];
        r.blue = ch[2];
        r.alpha = ch[3];
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        for (int i = 0; i < 65536; i++) image_mem[i] = 32'd0;
    end

    always @(posedge i_clk) begin
        t_pixel_out want;
        if (!i_rst_n) begin
            width_reg <= 9'd256;
            height_reg <= 9'd256;
            step_x <= 24'd65536;
            step_y <= 24'd65536;
            pixels_due.delete();
        end else begin
            if (i_valid_out && i_ready) begin
                if (pixels_due.size() == 0) begin
                    $error("Result pixel (%0d,%0d) with no request outstanding",
                           i_out_x, i_out_y);
                    o_fail_count++;
                end else begin
                    want = pixels_due.pop_front();
                    check_field("out_x", want.x, i_out_x);
                    check_field("out_y", want.y, i_out_y);
                    check_field("out_red", want.red, i_out_red);
                    check_field("out_green", want.green, i_out_green);
                    check_field("out_blue", want.blue, i_out_blue);
                    check_field("out_alpha", want.alpha, i_out_alpha);
                end
            end
            if (i_valid && i_ready_in) begin
                if (t_op'(i_op) == OP_LOAD) begin
                    image_mem[{i_coord_y, i_coord_x}] =
                        {i_in_alpha, i_in_blue, i_in_green, i_in_red};
                end else begin
                    pixels_due = {pixels_due, blend_pixel(i_coord_x, i_coord_y)};
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SRC_WIDTH:  width_reg <= i_cfg_data[8:0];
                    CFG_SRC_HEIGHT: height_reg <= i_cfg_data[8:0];
                    CFG_SCALE_X:    step_x <= i_cfg_data;
                    CFG_SCALE_Y:    step_y <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = pixels_due.size();
    end

endmodule

FILE: tb/tb_top.sv
// Top of the bilinear image resize testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
    import bir_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [23:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_op;
    logic [7:0]  i_coord_x;
    logic [7:0]  i_coord_y;
    logic [7:0]  i_in_red;
    logic [7:0]  i_in_green;
    logic [7:0]  i_in_blue;
    logic [7:0]  i_in_alpha;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_out_x;
    logic [7:0]  o_out_y;
    logic [7:0]  o_out_red;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_blue;
    logic [7:0]  o_out_alpha;
    int          fail_count;
    int          pending;
    bit          written [0:65535];
    bit          send_idle_en;
    int          load_count;
    int          sample_count;
    int          setting_count;
    int          wait_cycles;

    bilinear_image_resize_unit dut (.*);

    bir_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .i_ready_in(o_ready), .i_op, .i_coord_x, .i_coord_y,
        .i_in_red, .i_in_green, .i_in_blue, .i_in_alpha,
        .i_valid_out(o_valid), .i_ready, .i_out_x(o_out_x), .i_out_y(o_out_y),
        .i_out_red(o_out_red), .i_out_green(o_out_green), .i_out_blue(o_out_blue),
        .i_out_alpha(o_out_alpha), .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

    // The receiver holds off once for a long stretch while random traffic is running.
    initial begin
        int cycle;
        bit held;
        i_ready = 1'b0;
        cycle = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            cycle++;
            if (!held && i_rst_n && sample_count >= 25) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (80) @(posedge i_clk);
            end
            if (cycle > 2000 && cycle < 3500) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= 20);
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [23:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_request(t_op op, logic [7:0] x, logic [7:0] y, logic [31:0] pix);
        while (send_idle_en && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_coord_x <= x;
        i_coord_y <= y;
        {i_in_alpha, i_in_blue, i_in_green, i_in_red} <= pix;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (op == OP_LOAD) begin
            written[{y, x}] = 1'b1;
            load_count++;
        end else begin
            sample_count++;
        end
    endtask

    task automatic drain_block();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_geometry(logic [8:0] w, logic [8:0] h, logic [23:0] sx,
                                logic [23:0] sy);
        int ew;
        int eh;
        drain_block();
        write_reg(CFG_SRC_WIDTH, 24'(w));
        write_reg(CFG_SRC_HEIGHT, 24'(h));
        write_reg(CFG_SCALE_X, sx);
        write_reg(CFG_SCALE_Y, sy);
        setting_count++;
        ew = (w == 0) ? 1 : (w > 256) ? 256 : w;
        eh = (h == 0) ? 1 : (h > 256) ? 256 : h;
        for (int y = 0; y < eh; y++) begin
            for (int x = 0; x < ew; x++) begin
                if (!written[{y[7:0], x[7:0]}]) begin
                    send_request(OP_LOAD, x[7:0], y[7:0], $urandom);
                end
            end
        end
    endtask

    initial begin
        int w;
        int h;
        logic [23:0] sx;
        logic [23:0] sy;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_SRC_WIDTH;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_op = OP_LOAD;
        i_coord_x = '0;
        i_coord_y = '0;
        {i_in_alpha, i_in_blue, i_in_green, i_in_red} = '0;
        send_idle_en = 1'b1;
        load_count = 0;
        sample_count = 0;
        setting_count = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wide single row with maximum horizontal step and zero vertical step.
        set_geometry(9'd256, 9'd1, 24'hFFFFFF, 24'd0);
        send_request(OP_SAMPLE, 8'd0, 8'd0, 32'd0);
        send_request(OP_SAMPLE, 8'd255, 8'd255, 32'hFFFFFFFF);
        send_request(OP_SAMPLE, 8'd1, 8'd128, 32'd0);
        // Single column, width register zero, maximum vertical step.
        set_geometry(9'd0, 9'd256, 24'd0, 24'hFFFFFF);
        send_request(OP_SAMPLE, 8'd0, 8'd0, 32'd0);
        send_request(OP_SAMPLE, 8'd255, 8'd255, 32'd0);
        send_request(OP_SAMPLE, 8'd7, 8'd1, 32'd0);
        // Oversized width, half horizontal and three-quarter vertical steps, no sender idling here.
        send_idle_en = 1'b0;
        set_geometry(9'd511, 9'd2, 24'h008000, 24'h00C000);
        send_request(OP_SAMPLE, 8'd0, 8'd0, 32'd0);
        send_request(OP_SAMPLE, 8'd255, 8'd1, 32'd0);
        send_request(OP_SAMPLE, 8'd3, 8'd3, 32'd0);
        send_request(OP_SAMPLE, 8'd170, 8'd85, 32'd0);
        // Zero scale in both directions and the reset-value step.
        set_geometry(9'd4, 9'd4, 24'd0, 24'd0);
        send_request(OP_SAMPLE, 8'd200, 8'd100, 32'd0);
        set_geometry(9'd4, 9'd4, 24'd65536, 24'd65536);
        for (int i = 0; i < 6; i++) begin
            send_request(OP_SAMPLE, i[7:0], 8'(5 - i), 32'd0);
        end
        send_idle_en = 1'b1;

        for (int ph = 0; ph < 6; ph++) begin
            w = $urandom_range(1, 16);
            h = $urandom_range(1, 16);
            sx = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4 << 16));
            sy = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4 << 16));
            set_geometry(w[8:0], h[8:0], sx, sy);
            for (int i = 0; i < 30; i++) begin
                if ($urandom_range(99) < 70) begin
                    send_request(OP_SAMPLE, 8'($urandom), 8'($urandom), $urandom);
                end else if ($urandom_range(9) == 0) begin
                    send_request(OP_LOAD, 8'($urandom), 8'($urandom), $urandom);
                end else begin
                    send_request(OP_LOAD, 8'($urandom_range(0, w - 1)),
                                 8'($urandom_range(0, h - 1)), $urandom);
                end
            end
        end

        i_valid <= 1'b0;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (20) @(posedge i_clk);
        $display("Covered %0d pixel loads and %0d samples over %0d geometry settings.",
                 load_count, sample_count, setting_count);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            if (pending != 0) $error("%0d result pixels never arrived", pending);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/bir_pkg.sv
design/bir_front.sv
design/bir_queue.sv
design/bir_back.sv
design/bilinear_image_resize_unit.sv
tb/bir_checker.sv
tb/tb_top.sv
